// File: design/afr_pkg.sv
package afr_pkg;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_TYPE   = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;

    localparam logic [7:0] DELIMITER = 8'h7E;
    localparam logic [7:0] SUM_GOOD  = 8'hFF;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_kind;
        logic [15:0] frame_length;
        logic [1:0]  frame_status;
        logic        last;
    } afr_result_t;

endpackage

// File: design/afr_deframer.sv
module afr_deframer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    input  logic                 out_free,
    output logic                 consume,
    output logic                 res_valid,
    output afr_pkg::afr_result_t res
);

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic [15:0] pos_reg;
    logic [15:0] pos_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic [16:0] pos_inc;
    logic [7:0]  total;
    logic        in_body;

    assign in_body   = (phase_reg == afr_pkg::PH_BODY);
    assign consume   = byte_valid && (!in_body || out_free);
    assign res_valid = consume && in_body;
    assign pos_inc   = {1'b0, pos_reg} + 17'd1;
    assign total     = sum_reg + byte_data;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;

        res.item_kind     = afr_pkg::KIND_DATA;
        res.payload_byte  = 8'd0;
        res.payload_index = 16'd0;
        res.frame_kind    = type_reg;
        res.frame_length  = len_reg;
        res.frame_status  = afr_pkg::ST_GOOD;
        res.last          = 1'b0;

        unique case (phase_reg)
            afr_pkg::PH_LEN_HI:
            begin
                len_next   = {byte_data, 8'd0};
                phase_next = afr_pkg::PH_LEN_LO;
            end
            afr_pkg::PH_LEN_LO:
            begin
                len_next   = {len_reg[15:8], byte_data};
                phase_next = afr_pkg::PH_TYPE;
            end
            afr_pkg::PH_TYPE:
            begin
                type_next  = byte_data;
                sum_next   = byte_data;
                pos_next   = 16'd0;
                phase_next = afr_pkg::PH_BODY;
            end
            afr_pkg::PH_BODY:
            begin
                if (len_reg == 16'd0)
                begin
                    res.item_kind    = afr_pkg::KIND_END;
                    res.frame_status = afr_pkg::ST_ZERO_LEN;
                    res.last         = 1'b1;
                    phase_next       = afr_pkg::PH_HUNT;
                end
                else if (pos_inc < {1'b0, len_reg})
                begin
                    res.payload_byte  = byte_data;
                    res.payload_index = pos_reg;
                    sum_next          = total;
                    pos_next          = pos_inc[15:0];
                end
                else
                begin
                    res.item_kind    = afr_pkg::KIND_END;
                    res.frame_status = (total == afr_pkg::SUM_GOOD) ?
                                       afr_pkg::ST_GOOD : afr_pkg::ST_BAD_SUM;
                    res.last         = 1'b1;
                    phase_next       = afr_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = (byte_data == afr_pkg::DELIMITER) ?
                             afr_pkg::PH_LEN_HI : afr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= afr_pkg::PH_HUNT;
            len_reg   <= 16'd0;
            pos_reg   <= 16'd0;
            sum_reg   <= 8'd0;
            type_reg  <= 8'd0;
        end
        else if (consume)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_body && len_reg != 16'd0) |-> (pos_reg < len_reg))
        else $error("position past declared length");

    a_body_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && in_body && !out_free) |=> $stable(pos_reg) && $stable(phase_reg))
        else $error("body byte consumed without output room");

endmodule

// File: design/afr_out_reg.sv
module afr_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  afr_pkg::afr_result_t res,
    input  logic                 out_stall,
    output logic                 free,
    output logic                 out_valid,
    output afr_pkg::afr_result_t out_res
);

    logic                 valid_reg;
    afr_pkg::afr_result_t data_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            data_reg <= res;
        end
    end

endmodule

// File: design/api_frame_receiver_top.sv
// API frame receiver.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per
// request. Output channel: out_valid / out_stall carry one result per
// request: either a payload byte with its index, or an end of frame status
// (last = 1) with status good, checksum mismatch or zero length.
// Delimiter, length and frame type bytes produce no result; bytes outside
// a frame other than the delimiter are dropped.
// Path: a taken byte is held in the input register, decoded combinationally,
// and its result is registered in the output register once that has room.
// Throughput: one byte per cycle unless a result byte waits for output room,
// limited by the single decode stage between the input and output registers.
// Stall: while the output register holds an untaken result, a byte that
// would produce a result waits in the input register and in_stall rises;
// header bytes keep flowing since they need no output slot.
// Reset: asynchronous, active low; both registers empty, parser hunting
// for the delimiter with length, position, sum and type cleared.
module api_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index,
    output logic [7:0]  frame_kind,
    output logic [15:0] frame_length,
    output logic [1:0]  frame_status,
    output logic        last
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 consume;
    logic                 res_valid;
    logic                 out_free;
    afr_pkg::afr_result_t res;
    afr_pkg::afr_result_t out_res;

    assign in_stall = in_valid_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    afr_deframer u_deframer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg),
        .byte_data  (in_byte_reg),
        .out_free   (out_free),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res)
    );

    afr_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign item_kind     = out_res.item_kind;
    assign payload_byte  = out_res.payload_byte;
    assign payload_index = out_res.payload_index;
    assign frame_kind    = out_res.frame_kind;
    assign frame_length  = out_res.frame_length;
    assign frame_status  = out_res.frame_status;
    assign last          = out_res.last;

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == item_kind))
        else $error("last and item kind disagree");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && item_kind == afr_pkg::KIND_DATA) |->
            (frame_status == afr_pkg::ST_GOOD))
        else $error("status set on payload item");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid)
        else $error("decoded result not registered");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid && out_stall))
        else $error("input stalled without output backpressure");

endmodule

// File: test/api_frame_receiver_top_tb.sv
module api_frame_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int BYTE_TARGET = 1250;

    typedef struct {
        logic [7:0]           rx;
        bit                   typed;
        afr_pkg::afr_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_kind;
    logic [15:0] frame_length;
    logic [1:0]  frame_status;
    logic        last;

    // deframer state as seen by the predictor
    logic [2:0]  prs_phase = afr_pkg::PH_HUNT;
    logic [15:0] prs_len = '0;
    logic [15:0] prs_pos = '0;
    logic [7:0]  prs_sum = '0;
    logic [7:0]  prs_type = '0;

    afr_pkg::afr_result_t pending_results[$];

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int cycle_cnt = 0;
    int mismatches = 0;
    int results_seen = 0;
    int frame_bytes = 0;
    int frames_sent = 0;
    int ends_good = 0;
    int ends_bad = 0;
    int ends_zero = 0;

    api_frame_receiver_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_kind     (item_kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_kind    (frame_kind),
        .frame_length  (frame_length),
        .frame_status  (frame_status),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    function automatic afr_pkg::afr_result_t end_item(input logic [7:0] ftype,
                                                      input logic [15:0] flen,
                                                      input logic [1:0] status);
        afr_pkg::afr_result_t r;
        r = '0;
        r.item_kind = afr_pkg::KIND_END;
        r.frame_kind = ftype;
        r.frame_length = flen;
        r.frame_status = status;
        r.last = 1'b1;
        return r;
    endfunction

    // advances the deframer by one byte; returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b,
                                        output afr_pkg::afr_result_t r);
        logic [7:0] total;
        r = '0;
        deframe_byte = 1'b0;
        case (prs_phase)
            afr_pkg::PH_LEN_HI:
            begin
                prs_len = {b, 8'h00};
                prs_phase = afr_pkg::PH_LEN_LO;
            end
            afr_pkg::PH_LEN_LO:
            begin
                prs_len[7:0] = b;
                prs_phase = afr_pkg::PH_TYPE;
            end
            afr_pkg::PH_TYPE:
            begin
                prs_type = b;
                prs_sum = b;
                prs_pos = '0;
                prs_phase = afr_pkg::PH_BODY;
            end
            afr_pkg::PH_BODY:
            begin
                deframe_byte = 1'b1;
                r.frame_kind = prs_type;
                r.frame_length = prs_len;
                if (prs_len == 16'd0)
                begin
                    r = end_item(prs_type, prs_len, afr_pkg::ST_ZERO_LEN);
                    prs_phase = afr_pkg::PH_HUNT;
                end
                else if (prs_pos < prs_len - 16'd1)
                begin
                    r.item_kind = afr_pkg::KIND_DATA;
                    r.payload_byte = b;
                    r.payload_index = prs_pos;
                    prs_sum = prs_sum + b;
                    prs_pos = prs_pos + 16'd1;
                end
                else
                begin
                    total = prs_sum + b;
                    r = end_item(prs_type, prs_len,
                                 (total == afr_pkg::SUM_GOOD) ?
                                 afr_pkg::ST_GOOD : afr_pkg::ST_BAD_SUM);
                    prs_phase = afr_pkg::PH_HUNT;
                end
            end
            default:
                prs_phase = (b == afr_pkg::DELIMITER) ? afr_pkg::PH_LEN_HI : afr_pkg::PH_HUNT;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input afr_pkg::afr_result_t typed_r);
        afr_pkg::afr_result_t r;
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (deframe_byte(b, r))
            pending_results.push_back(typed ? typed_r : r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [15:0] len, input bit good_sum);
        logic [7:0] ftype;
        logic [7:0] b;
        logic [7:0] sum;
        ftype = 8'($urandom_range(0, 255));
        send_byte(afr_pkg::DELIMITER, 1'b0, '0);
        send_byte(len[15:8], 1'b0, '0);
        send_byte(len[7:0], 1'b0, '0);
        send_byte(ftype, 1'b0, '0);
        sum = ftype;
        for (int i = 0; i < int'(len) - 1; i++)
        begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b, 1'b0, '0);
        end
        send_byte(good_sum ? afr_pkg::SUM_GOOD - sum : 8'($urandom_range(0, 255)),
                  1'b0, '0);
        frame_bytes += int'(len) + 4;
        frames_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        afr_pkg::afr_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $error("result with no request pending");
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("item_kind", 16'(want.item_kind), 16'(item_kind));
                check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
                check_field("payload_index", want.payload_index, payload_index);
                check_field("frame_kind", 16'(want.frame_kind), 16'(frame_kind));
                check_field("frame_length", want.frame_length, frame_length);
                check_field("frame_status", 16'(want.frame_status), 16'(frame_status));
                check_field("last", 16'(want.last), 16'(last));
                if (want.last)
                begin
                    case (want.frame_status)
                        afr_pkg::ST_GOOD:     ends_good++;
                        afr_pkg::ST_BAD_SUM:  ends_bad++;
                        default:              ends_zero++;
                    endcase
                end
            end
        end
    end

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        stim_row_t directed[$];
        bit held;
        int r;
        logic [15:0] len;
        logic [7:0] b;

        held = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;

        // noise while hunting
        directed.push_back('{8'h00, 1'b0, '0});
        directed.push_back('{8'hFF, 1'b0, '0});
        // zero length frame
        directed.push_back('{afr_pkg::DELIMITER, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, '0});
        directed.push_back('{8'hA5, 1'b0, '0});
        directed.push_back('{8'h33, 1'b1, end_item(8'hA5, 16'd0, afr_pkg::ST_ZERO_LEN)});
        // length one, checksum only
        directed.push_back('{afr_pkg::DELIMITER, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, '0});
        directed.push_back('{8'h01, 1'b0, '0});
        directed.push_back('{8'hFF, 1'b0, '0});
        directed.push_back('{8'h00, 1'b1, end_item(8'hFF, 16'd1, afr_pkg::ST_GOOD)});
        // delimiter value inside payload, bad checksum
        directed.push_back('{afr_pkg::DELIMITER, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, '0});
        directed.push_back('{8'h03, 1'b0, '0});
        directed.push_back('{8'h10, 1'b0, '0});
        directed.push_back('{afr_pkg::DELIMITER, 1'b0, '0});
        directed.push_back('{8'h81, 1'b0, '0});
        directed.push_back('{8'h00, 1'b1, end_item(8'h10, 16'd3, afr_pkg::ST_BAD_SUM)});
        // one payload byte, good checksum
        directed.push_back('{afr_pkg::DELIMITER, 1'b0, '0});
        directed.push_back('{8'h00, 1'b0, '0});
        directed.push_back('{8'h02, 1'b0, '0});
        directed.push_back('{8'h01, 1'b0, '0});
        directed.push_back('{8'hFE, 1'b0, '0});
        directed.push_back('{8'h00, 1'b1, end_item(8'h01, 16'd2, afr_pkg::ST_GOOD)});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i].rx, directed[i].typed, directed[i].want);
        drain();

        while (frame_bytes < BYTE_TARGET)
        begin
            quiet = ($urandom_range(0, 9) == 0);
            if (!held && frame_bytes > BYTE_TARGET / 2)
            begin
                // long receiver hold-off while requests keep coming
                quiet = 1'b0;
                held = 1'b1;
                hold_req = 1'b1;
                send_frame(16'd40, 1'b1);
                drain();
            end
            else if ($urandom_range(0, 99) < 85)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    b = 8'($urandom_range(0, 255));
                    send_byte((b == afr_pkg::DELIMITER) ? 8'h00 : b, 1'b0, '0);
                end
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = 16'd0;
                else if (r < 90)
                    len = 16'($urandom_range(1, 24));
                else
                    len = 16'($urandom_range(25, 300));
                send_frame(len, $urandom_range(0, 9) < 7);
            end
            else
            begin
                // raw bytes, may start or cut into frames
                repeat ($urandom_range(1, 10))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
        quiet = 1'b0;
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d frames (%0d framed bytes), checked %0d results in %0d cycles",
                 frames_sent, frame_bytes, results_seen, cycle_cnt);
        $display("Frame ends: %0d good, %0d checksum mismatch, %0d zero length; %0d mismatches",
                 ends_good, ends_bad, ends_zero, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
